// File: hdl/wpcm_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM16 chunk decoder package
// Shared types, codes and constants for the chunk parser and its datapath.
// ----------------------------------------------------------------------------
package wpcm_pkg;

  // RIFF/WAVE header length, chunk header length and the data chunk tag
  localparam logic [31:0] RIFF_HEADER_BYTES = 32'd12;
  localparam logic [32:0] CHUNK_HDR_BYTES   = 33'd8;
  localparam logic [31:0] TAG_DATA          = 32'h6174_6164;

  // Format chunk values that are accepted
  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] FMT_BITS = 16'd16;

  // Sample limit after reset
  localparam logic [31:0] SAMPLE_LIMIT_RST = 32'd16777216;

  // Steps of the bit-serial remainder unit
  localparam int DIV_STEPS = 32;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SAMPLE        = 3'd0,
    ST_EMPTY         = 3'd1,
    ST_BAD_FORMAT    = 3'd2,
    ST_OVERRUN       = 3'd3,
    ST_SIZE_MISMATCH = 3'd4,
    ST_NO_DATA       = 3'd5
  } status_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_TOTAL_LENGTH = 3'd0,
    REG_HEADER_VALID = 3'd1,
    REG_AUDIO_FORMAT = 3'd2,
    REG_SAMPLE_BITS  = 3'd3,
    REG_BLOCK_ALIGN  = 3'd4,
    REG_DATA_SIZE    = 3'd5,
    REG_SAMPLE_LIMIT = 3'd6
  } reg_idx_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [31:0] total_length;
    logic        header_valid;
    logic [15:0] audio_format;
    logic [15:0] sample_bits;
    logic [15:0] block_align;
    logic [31:0] data_size;
    logic [31:0] sample_limit;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    restart;
    logic    adv;
    logic    hdr_shift;
    logic    rem_load8;
    logic    rem_load_size;
    logic    rem_dec;
    logic    skip_pad;
    logic    pad_clr;
    logic    pad_set;
    logic    pad_load_size;
    logic    low_load;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller, valid for the item on the port
  typedef struct packed {
    logic past_end;
    logic pos_zero;
    logic hdr_done;
    logic at_end;
    logic no_room;
    logic hdr_last;
    logic overrun;
    logic is_data;
    logic size_match;
    logic size_short;
    logic size_zero;
    logic skip_end;
    logic pad;
    logic data_last;
  } dp_stat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    status_t            status;
    logic               last;
  } result_t;

endpackage

// File: hdl/wpcm_cfg.sv
// ----------------------------------------------------------------------------
// WPCM configuration registers
// APB-style register file holding file length, format fields and limits.
// ----------------------------------------------------------------------------
module wpcm_cfg import wpcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output logic        wr_pulse
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  assign idx      = reg_idx_t'(paddr[4:2]);
  assign wr_pulse = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign cfg      = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_pulse) begin
      case (idx)
        REG_TOTAL_LENGTH: cfg_nxt.total_length = pwdata;
        REG_HEADER_VALID: cfg_nxt.header_valid = pwdata[0];
        REG_AUDIO_FORMAT: cfg_nxt.audio_format = pwdata[15:0];
        REG_SAMPLE_BITS:  cfg_nxt.sample_bits  = pwdata[15:0];
        REG_BLOCK_ALIGN:  cfg_nxt.block_align  = pwdata[15:0];
        REG_DATA_SIZE:    cfg_nxt.data_size    = pwdata;
        REG_SAMPLE_LIMIT: cfg_nxt.sample_limit = pwdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TOTAL_LENGTH: prdata = cfg_r.total_length;
      REG_HEADER_VALID: prdata = {31'd0, cfg_r.header_valid};
      REG_AUDIO_FORMAT: prdata = {16'd0, cfg_r.audio_format};
      REG_SAMPLE_BITS:  prdata = {16'd0, cfg_r.sample_bits};
      REG_BLOCK_ALIGN:  prdata = {16'd0, cfg_r.block_align};
      REG_DATA_SIZE:    prdata = cfg_r.data_size;
      REG_SAMPLE_LIMIT: prdata = cfg_r.sample_limit;
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{total_length: '0, header_valid: 1'b0, audio_format: '0,
                 sample_bits: '0, block_align: '0, data_size: '0,
                 sample_limit: SAMPLE_LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/wpcm_fmt.sv
// ----------------------------------------------------------------------------
// WPCM format checker
// Bit-serial remainder of data_size by block_align plus the field checks.
// ----------------------------------------------------------------------------
module wpcm_fmt import wpcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  cfg_t cfg,
  output logic busy,
  output logic fmt_ok
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      dvd_r, dvd_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [31:0]      src;
  logic [16:0]      trial;
  logic             fields_ok;

  // First step reads the dividend straight from the register, which is
  // settled by then; later steps use the shifted copy
  assign src   = (cnt_r == '0) ? cfg.data_size : dvd_r;

  // One quotient bit per cycle
  assign trial = {rem_r, src[31]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {src[30:0], 1'b0};
      if (trial >= {1'b0, cfg.block_align}) begin
        rem_nxt = 16'(trial - {1'b0, cfg.block_align});
      end else begin
        rem_nxt = trial[15:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
  end

  // Field checks; the remainder is final once busy drops
  assign fields_ok = cfg.header_valid && (cfg.audio_format == FMT_PCM) &&
                     (cfg.sample_bits == FMT_BITS) && (cfg.block_align != 16'd0) &&
                     ({1'b0, cfg.data_size[31:1]} <= cfg.sample_limit);

  assign fmt_ok = fields_ok && (rem_r == 16'd0);
  assign busy   = busy_r;

endmodule

// File: hdl/wpcm_ctrl.sv
// ----------------------------------------------------------------------------
// WPCM parse controller
// Phase state machine: header skip, chunk header, chunk skip, data, done.
// ----------------------------------------------------------------------------
module wpcm_ctrl import wpcm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  logic     stream_start,
  input  logic     fmt_ok,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  phase_t state_r, state_nxt;
  phase_t st_eff;
  logic   bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    bnd       = 1'b0;
    st_eff    = state_r;
    if (accept) begin
      // Restart the file on a start item
      cmd.restart = stream_start;
      if (stream_start) begin
        st_eff    = PH_HEADER;
        state_nxt = PH_HEADER;
      end
      if ((st_eff != PH_DONE) && !stat.past_end) begin
        cmd.adv = 1'b1;
        if (stat.pos_zero && !fmt_ok) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BAD_FORMAT;
          cmd.emit_last   = 1'b1;
        end else begin
          case (st_eff)
            PH_HEADER: begin
              if (stat.hdr_done) begin
                bnd = 1'b1;
              end else if (stat.at_end) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NO_DATA;
                cmd.emit_last   = 1'b1;
              end
            end
            PH_CHUNK: begin
              cmd.hdr_shift = 1'b1;
              if (!stat.hdr_last) begin
                cmd.rem_dec = 1'b1;
              end else if (stat.overrun) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_OVERRUN;
                cmd.emit_last   = 1'b1;
              end else if (stat.is_data) begin
                if (!stat.size_match) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_SIZE_MISMATCH;
                  cmd.emit_last   = 1'b1;
                end else if (stat.size_short) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_EMPTY;
                  cmd.emit_last   = 1'b1;
                end else begin
                  state_nxt         = PH_DATA;
                  cmd.rem_load_size = 1'b1;
                  cmd.pad_clr       = 1'b1;
                end
              end else begin
                // Skip any other chunk plus its pad byte
                state_nxt         = PH_SKIP;
                cmd.rem_load_size = 1'b1;
                cmd.pad_load_size = 1'b1;
                if (stat.size_zero) begin
                  bnd = 1'b1;
                end else if (stat.at_end) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_NO_DATA;
                  cmd.emit_last   = 1'b1;
                end
              end
            end
            PH_SKIP: begin
              cmd.rem_dec  = 1'b1;
              cmd.skip_pad = 1'b1;
              if (stat.skip_end) begin
                bnd = 1'b1;
              end else if (stat.at_end) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NO_DATA;
                cmd.emit_last   = 1'b1;
              end
            end
            PH_DATA: begin
              cmd.rem_dec = 1'b1;
              if (!stat.pad) begin
                cmd.low_load = 1'b1;
                cmd.pad_set  = 1'b1;
              end else begin
                cmd.pad_clr     = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_SAMPLE;
                cmd.emit_last   = stat.data_last;
              end
            end
            default: begin
              cmd.adv = 1'b0;
            end
          endcase
        end
      end
      // Chunk boundary: open the next header or report no data chunk
      if (bnd) begin
        if (stat.no_room) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NO_DATA;
          cmd.emit_last   = 1'b1;
        end else begin
          state_nxt     = PH_CHUNK;
          cmd.rem_load8 = 1'b1;
        end
      end
      // Drop everything after a final result
      if (cmd.emit && cmd.emit_last) begin
        state_nxt = PH_DONE;
      end
    end
  end

endmodule

// File: hdl/wpcm_dp.sv
// ----------------------------------------------------------------------------
// WPCM datapath
// Byte position, chunk header shifter, remaining count and sample assembly.
// ----------------------------------------------------------------------------
module wpcm_dp import wpcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        stream_start,
  input  logic [7:0]  data_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        res_valid,
  output result_t     res
);

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        pad_r, pad_nxt;
  logic [55:0] hdr_r;
  logic [7:0]  low_r;
  logic [31:0] pos_eff, pos1;
  logic [31:0] size;
  logic [31:0] left;

  assign pos_eff = stream_start ? 32'd0 : pos_r;
  assign pos1    = pos_eff + 32'd1;
  assign size    = {data_byte, hdr_r[55:32]};
  assign left    = cfg.total_length - pos1;

  // Flags for the item on the input port
  always_comb begin
    stat            = '0;
    stat.past_end   = pos_eff >= cfg.total_length;
    stat.pos_zero   = pos_eff == 32'd0;
    stat.hdr_done   = pos1 >= RIFF_HEADER_BYTES;
    stat.at_end     = pos1 >= cfg.total_length;
    stat.no_room    = ({1'b0, pos1} + CHUNK_HDR_BYTES) > {1'b0, cfg.total_length};
    stat.hdr_last   = rem_r == 32'd1;
    stat.overrun    = size > left;
    stat.is_data    = hdr_r[31:0] == TAG_DATA;
    stat.size_match = size == cfg.data_size;
    stat.size_short = size < 32'd2;
    stat.size_zero  = size == 32'd0;
    stat.skip_end   = (rem_r == 32'd0) || ((rem_r == 32'd1) && !pad_r);
    stat.pad        = pad_r;
    stat.data_last  = rem_r <= 32'd2;
  end

  // Next values of the counters
  always_comb begin
    if (cmd.adv) begin
      pos_nxt = pos1;
    end else if (cmd.restart) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r;
    end

    if (cmd.rem_load8) begin
      rem_nxt = CHUNK_HDR_BYTES[31:0];
    end else if (cmd.rem_load_size) begin
      rem_nxt = size;
    end else if (cmd.rem_dec && (rem_r != 32'd0)) begin
      rem_nxt = rem_r - 32'd1;
    end else if (cmd.restart) begin
      rem_nxt = '0;
    end else begin
      rem_nxt = rem_r;
    end

    if (cmd.pad_load_size) begin
      pad_nxt = size[0];
    end else if (cmd.pad_clr) begin
      pad_nxt = 1'b0;
    end else if (cmd.pad_set) begin
      pad_nxt = 1'b1;
    end else if (cmd.skip_pad && (rem_r == 32'd0)) begin
      pad_nxt = 1'b0;
    end else if (cmd.restart) begin
      pad_nxt = 1'b0;
    end else begin
      pad_nxt = pad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rem_r <= '0;
      pad_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      rem_r <= rem_nxt;
      pad_r <= pad_nxt;
    end
  end

  // Header shifter and held low byte
  always_ff @(posedge clk) begin
    if (cmd.hdr_shift) begin
      hdr_r <= {data_byte, hdr_r[55:8]};
    end
    if (cmd.low_load) begin
      low_r <= data_byte;
    end
  end

  // Q1.15 sample is the raw little-endian word
  always_comb begin
    res_valid  = cmd.emit;
    res.status = cmd.emit_status;
    res.last   = cmd.emit_last;
    if (cmd.emit_status == ST_SAMPLE) begin
      res.sample = {data_byte, low_r};
    end else begin
      res.sample = '0;
    end
  end

endmodule

// File: hdl/wpcm_obuf.sv
// ----------------------------------------------------------------------------
// WPCM output buffer
// Output register plus one skid entry between parser and result channel.
// ----------------------------------------------------------------------------
module wpcm_obuf import wpcm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t dout,
  output logic    can_take
);

  logic    ov_r, ov_nxt;
  logic    sv_r, sv_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = ov_r && out_ready;

  always_comb begin
    ov_nxt   = ov_r;
    sv_nxt   = sv_r;
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (sv_r) begin
      // Refill from the skid entry
      if (pop) begin
        out_nxt = skid_r;
        sv_nxt  = 1'b0;
      end
    end else if (push) begin
      if (ov_r && !pop) begin
        skid_nxt = din;
        sv_nxt   = 1'b1;
      end else begin
        out_nxt = din;
        ov_nxt  = 1'b1;
      end
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = ov_r;
  assign dout      = out_r;
  assign can_take  = !sv_r;

endmodule

// File: hdl/wav_pcm16_chunk_decoder_top.sv
// Throughput: one byte item per cycle while in_ready is high.
// Output: the result register drives the output channel; one skid entry
//   lets an item be taken while an earlier result still waits.
// After any configuration write, input stalls while the serial
//   remainder unit checks block_align against data_size (one bit a cycle).
// Reset (rst_n low, synchronous): registers to reset values, parser to header skip.
// ----------------------------------------------------------------------------
// WAV PCM16 chunk decoder top level
// Walks RIFF chunks byte by byte and emits the data chunk as Q1.15 samples.
// ----------------------------------------------------------------------------
module wav_pcm16_chunk_decoder_top import wpcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_stream_start,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic [2:0]         out_status,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t     cfg;
  logic     wr_pulse;
  logic     fmt_busy;
  logic     fmt_ok;
  logic     accept;
  logic     can_take;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     res_valid;
  result_t  res;
  result_t  dout;

  // Take an item when the format check is settled and there is room for a result
  assign in_ready = !fmt_busy && can_take;
  assign accept   = in_valid && in_ready;

  wpcm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .wr_pulse (wr_pulse)
  );

  wpcm_fmt u_fmt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wr_pulse),
    .cfg    (cfg),
    .busy   (fmt_busy),
    .fmt_ok (fmt_ok)
  );

  wpcm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .stream_start (in_stream_start),
    .fmt_ok       (fmt_ok),
    .stat         (stat),
    .cmd          (cmd)
  );

  wpcm_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .stream_start (in_stream_start),
    .data_byte    (in_data_byte),
    .cmd          (cmd),
    .stat         (stat),
    .res_valid    (res_valid),
    .res          (res)
  );

  wpcm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dout      (dout),
    .can_take  (can_take)
  );

  assign out_sample = dout.sample;
  assign out_status = dout.status;
  assign out_last   = dout.last;

endmodule

// File: hdl/wpcm_chk.sv
// ----------------------------------------------------------------------------
// WPCM port checker
// Concurrent checks on the decoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
module wpcm_chk import wpcm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample,
  input logic [2:0]         out_status,
  input logic               out_last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
    $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // Every status other than a sample ends the file
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_SAMPLE) |-> out_last)
    else $error("terminal status without last");

  // A status item carries a zero sample
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_SAMPLE) |-> (out_sample == 16'sd0))
    else $error("status item with nonzero sample");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'd5))
    else $error("undefined status code");

  // Stall input while a new configuration is checked
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=> !in_ready)
    else $error("item taken during format check");

endmodule

bind wav_pcm16_chunk_decoder_top wpcm_chk u_wpcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_status (out_status),
  .out_last   (out_last),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite)
);

// File: verif/wav_pcm16_chunk_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// WAV PCM16 chunk decoder testbench
// Streams RIFF files into the decoder one byte per item and mirrors the chunk
// walk in a local decoder model. A short table covers reset, format errors and
// sample extremes; random well-formed, broken and noise files follow. Every
// emitted sample and status is checked in order against the model or the table.
// ----------------------------------------------------------------------------
module wav_pcm16_chunk_decoder_top_tb;
  import wpcm_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {ROW_CFG, ROW_MODEL, ROW_QUIET, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    logic        start;
    logic [7:0]  data;
    result_t     want;
  } stim_row_t;

  localparam result_t NOR = '0;

  // Directed table: typed rows carry the result read straight off the file layout
  localparam int DIR_ROWS = 38;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // bytes after reset are past a zero total length
    '{ROW_QUIET, REG_TOTAL_LENGTH, 32'd0,  1'b1, 8'hA5, NOR},
    '{ROW_CFG,   REG_TOTAL_LENGTH, 32'd3,  1'b0, 8'h00, NOR},
    // header not marked valid: format error on the first byte
    '{ROW_TYPED, REG_TOTAL_LENGTH, 32'd0,  1'b1, 8'h00, '{16'sh0000, ST_BAD_FORMAT, 1'b1}},
    '{ROW_QUIET, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_CFG,   REG_HEADER_VALID, 32'd1,  1'b0, 8'h00, NOR},
    '{ROW_CFG,   REG_AUDIO_FORMAT, 32'd1,  1'b0, 8'h00, NOR},
    '{ROW_CFG,   REG_SAMPLE_BITS,  32'd16, 1'b0, 8'h00, NOR},
    '{ROW_CFG,   REG_BLOCK_ALIGN,  32'd2,  1'b0, 8'h00, NOR},
    '{ROW_CFG,   REG_DATA_SIZE,    32'd4,  1'b0, 8'h00, NOR},
    // file ends inside the RIFF header
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b1, 8'h52, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h49, NOR},
    '{ROW_TYPED, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h46, '{16'sh0000, ST_NO_DATA, 1'b1}},
    '{ROW_CFG,   REG_TOTAL_LENGTH, 32'd24, 1'b0, 8'h00, NOR},
    // minimal file: header, data chunk of two samples at full scale
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b1, 8'h52, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h49, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h46, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h46, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h57, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h41, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h56, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h45, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h64, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h61, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h74, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h61, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h04, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h00, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h00, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h00, NOR},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h00, NOR},
    '{ROW_TYPED, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h80, '{16'sh8000, ST_SAMPLE, 1'b0}},
    '{ROW_MODEL, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'hFF, NOR},
    '{ROW_TYPED, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h7F, '{16'sh7FFF, ST_SAMPLE, 1'b1}},
    // bytes after the final sample are dropped
    '{ROW_QUIET, REG_TOTAL_LENGTH, 32'd0,  1'b0, 8'h11, NOR}
  };

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_stream_start = 1'b0;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic [2:0]         out_status;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  wav_pcm16_chunk_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_start (in_stream_start),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_status      (out_status),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register mirror and decoder state of the local model
  cfg_t        cfg_now;
  logic [31:0] byte_pos;
  phase_t      parse_state;
  logic [63:0] hdr_sr;
  logic [31:0] remaining;
  logic        pad_flag;
  logic [7:0]  low_hold;
  logic        stream_done;

  result_t     pending_results [$];
  logic [7:0]  file_bytes [$];
  int          mismatch_count = 0;
  int          random_items = 0;
  int          cycle_count = 0;
  bit          held_once = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Queue a result the decoder owes
  function automatic void log_result(input result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Append one byte to the file under construction
  function automatic void add_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endfunction

  function automatic void restart_stream();
    byte_pos    = '0;
    parse_state = PH_HEADER;
    hdr_sr      = '0;
    remaining   = '0;
    pad_flag    = 1'b0;
    low_hold    = '0;
    stream_done = 1'b0;
  endfunction

  function automatic result_t make_status(input status_t st);
    result_t r;
    r.sample    = '0;
    r.status    = st;
    r.last      = 1'b1;
    stream_done = 1'b1;
    return r;
  endfunction

  function automatic bit format_ok();
    if (!cfg_now.header_valid || cfg_now.audio_format != FMT_PCM ||
        cfg_now.sample_bits != FMT_BITS) return 1'b0;
    if (cfg_now.block_align == 16'd0) return 1'b0;
    if (cfg_now.data_size % 32'(cfg_now.block_align) != 32'd0) return 1'b0;
    return (cfg_now.data_size >> 1) <= cfg_now.sample_limit;
  endfunction

  // Start a chunk header, or flag that no header fits in the rest of the file
  function automatic bit next_chunk(output result_t r);
    r = '0;
    if ({1'b0, byte_pos} + CHUNK_HDR_BYTES > {1'b0, cfg_now.total_length}) begin
      r = make_status(ST_NO_DATA);
      return 1'b1;
    end
    parse_state = PH_CHUNK;
    remaining   = 32'(CHUNK_HDR_BYTES);
    hdr_sr      = '0;
    return 1'b0;
  endfunction

  // End of a skipped chunk, or the file runs out inside it
  function automatic bit skip_check(output result_t r);
    r = '0;
    if (remaining == 32'd0 && !pad_flag) return next_chunk(r);
    if (byte_pos >= cfg_now.total_length) begin
      r = make_status(ST_NO_DATA);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the local decoder by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic start, input logic [7:0] b,
                                     output result_t r);
    logic [31:0] pos;
    logic [31:0] tag;
    logic [31:0] chunk_len;
    r = '0;
    if (start) restart_stream();
    if (stream_done || byte_pos >= cfg_now.total_length) return 1'b0;
    pos      = byte_pos;
    byte_pos = pos + 32'd1;
    if (pos == 32'd0 && !format_ok()) begin
      r = make_status(ST_BAD_FORMAT);
      return 1'b1;
    end
    case (parse_state)
      PH_HEADER: begin
        if (byte_pos >= RIFF_HEADER_BYTES) return next_chunk(r);
        if (byte_pos >= cfg_now.total_length) begin
          r = make_status(ST_NO_DATA);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_CHUNK: begin
        hdr_sr    = {b, hdr_sr[63:8]};
        remaining = (remaining - 32'd1) & 32'd7;
        if (remaining != 32'd0) return 1'b0;
        tag       = hdr_sr[31:0];
        chunk_len = hdr_sr[63:32];
        if (chunk_len > cfg_now.total_length - byte_pos) begin
          r = make_status(ST_OVERRUN);
          return 1'b1;
        end
        if (tag == TAG_DATA) begin
          if (chunk_len != cfg_now.data_size) begin
            r = make_status(ST_SIZE_MISMATCH);
            return 1'b1;
          end
          if (chunk_len < 32'd2) begin
            r = make_status(ST_EMPTY);
            return 1'b1;
          end
          parse_state = PH_DATA;
          remaining   = chunk_len;
          pad_flag    = 1'b0;
          return 1'b0;
        end
        pad_flag    = chunk_len[0];
        remaining   = chunk_len;
        parse_state = PH_SKIP;
        return skip_check(r);
      end
      PH_SKIP: begin
        if (remaining != 32'd0) remaining = remaining - 32'd1;
        else pad_flag = 1'b0;
        return skip_check(r);
      end
      PH_DATA: begin
        if (remaining != 32'd0) remaining = remaining - 32'd1;
        if (!pad_flag) begin
          low_hold = b;
          pad_flag = 1'b1;
          return 1'b0;
        end
        pad_flag = 1'b0;
        r.sample = {b, low_hold};
        r.status = ST_SAMPLE;
        r.last   = remaining < 32'd2;
        if (r.last) stream_done = 1'b1;
        return 1'b1;
      end
      default: begin
        r = make_status(ST_NO_DATA);
        return 1'b1;
      end
    endcase
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte, wait for the handshake, then log what it should produce
  task automatic send_byte(input logic start, input logic [7:0] b,
                           input row_kind_t kind, input result_t want);
    result_t predicted;
    bit      has_result;
    in_valid        <= 1'b1;
    in_stream_start <= start;
    in_data_byte    <= b;
    do @(posedge clk); while (!in_ready);
    has_result = decode_byte(start, b, predicted);
    case (kind)
      ROW_TYPED: log_result(want);
      ROW_QUIET: ;
      default: if (has_result) log_result(predicted);
    endcase
  endtask

  task automatic pause(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every pending result, then let any silent item finish
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TOTAL_LENGTH: cfg_now.total_length = val;
      REG_HEADER_VALID: cfg_now.header_valid = val[0];
      REG_AUDIO_FORMAT: cfg_now.audio_format = val[15:0];
      REG_SAMPLE_BITS:  cfg_now.sample_bits  = val[15:0];
      REG_BLOCK_ALIGN:  cfg_now.block_align  = val[15:0];
      REG_DATA_SIZE:    cfg_now.data_size    = val;
      REG_SAMPLE_LIMIT: cfg_now.sample_limit = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    pause(1);
    drain_results();
    write_reg(REG_TOTAL_LENGTH, c.total_length);
    write_reg(REG_HEADER_VALID, {31'd0, c.header_valid});
    write_reg(REG_AUDIO_FORMAT, {16'd0, c.audio_format});
    write_reg(REG_SAMPLE_BITS,  {16'd0, c.sample_bits});
    write_reg(REG_BLOCK_ALIGN,  {16'd0, c.block_align});
    write_reg(REG_DATA_SIZE,    c.data_size);
    write_reg(REG_SAMPLE_LIMIT, c.sample_limit);
  endtask

  function automatic void push_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_random(input int n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  function automatic void push_junk_chunk();
    logic [31:0] tag;
    logic [31:0] chunk_len;
    tag = $urandom;
    if (tag == TAG_DATA) tag[0] = ~tag[0];
    chunk_len = $urandom_range(0, 7);
    push_word(tag);
    push_word(chunk_len);
    push_random(int'(chunk_len) + int'(chunk_len[0]));
  endfunction

  function automatic void push_data_chunk(input logic [31:0] chunk_len);
    push_word(TAG_DATA);
    push_word(chunk_len);
    push_random(int'(chunk_len));
  endfunction

  // Build one file, configure for it and stream it in
  task automatic run_random_file();
    cfg_t c;
    int   scen;
    int   frames;
    int   len;
    int   hold_at;
    bit   gaps_on;
    logic start;
    scen = $urandom_range(0, 99);
    file_bytes.delete();
    c.header_valid = 1'b1;
    c.audio_format = FMT_PCM;
    c.sample_bits  = FMT_BITS;
    case ($urandom_range(0, 3))
      0: c.block_align = 16'd1;
      1: c.block_align = 16'd2;
      2: c.block_align = 16'd4;
      default: c.block_align = 16'd6;
    endcase
    frames = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
    c.data_size = 32'(c.block_align) * 32'(frames);
    case ($urandom_range(0, 3))
      0: c.sample_limit = 32'hFFFF_FFFF;
      1: c.sample_limit = c.data_size >> 1;
      2: c.sample_limit = (c.data_size >> 1) + 32'($urandom_range(1, 1000));
      default: c.sample_limit = SAMPLE_LIMIT_RST;
    endcase

    // RIFF header, leading chunks, then the chunk under test
    push_random(12);
    repeat ($urandom_range(0, 2)) push_junk_chunk();
    if (scen < 60 || (scen >= 86 && scen < 93)) begin
      push_data_chunk(c.data_size);
    end else if (scen < 70) begin
      push_data_chunk(c.data_size + 32'($urandom_range(1, 3)));
    end else if (scen < 78) begin
      push_word($urandom_range(0, 1) ? TAG_DATA : 32'($urandom));
      push_word($urandom | 32'h0000_0100);
      push_random($urandom_range(1, 6));
    end else if (scen < 86) begin
      push_junk_chunk();
    end else if (scen >= 93) begin
      file_bytes.delete();
      push_random($urandom_range(8, 40));
    end

    // Break one format field
    if (scen >= 86 && scen < 93) begin
      case ($urandom_range(0, 5))
        0: c.header_valid = 1'b0;
        1: c.audio_format = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        2: c.sample_bits  = 16'($urandom_range(0, 65535));
        3: c.block_align  = 16'h0000;
        4: c.block_align  = 16'hFFFF;
        default: c.sample_limit = (c.data_size >> 1) - 32'd1;
      endcase
    end

    len = file_bytes.size();
    case ($urandom_range(0, 9))
      7: begin
        c.total_length = 32'(len);
        push_random($urandom_range(1, 5));
      end
      8: c.total_length = 32'($urandom_range(1, len));
      9: c.total_length = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      default: c.total_length = 32'(len);
    endcase
    apply_config(c);

    gaps_on = $urandom_range(0, 3) != 0;
    hold_at = -1;
    if (!held_once || $urandom_range(0, 7) == 0) hold_at = $urandom_range(0, len - 1);
    foreach (file_bytes[i]) begin
      // hold the sender until the result side is empty
      if (i == hold_at) begin
        pause(1);
        drain_results();
        held_once = 1'b1;
      end
      start = (i == 0) ? (scen < 93 || $urandom_range(0, 1) == 1)
                       : ($urandom_range(0, 199) == 0 ||
                          (scen >= 93 && $urandom_range(0, 15) == 0));
      send_byte(start, file_bytes[i], ROW_MODEL, NOR);
      random_items++;
      if (gaps_on) pause(pick_gap());
    end
    pause(1);
  endtask

  // Receiver stalls: short and long, with long stretches of no stall
  int ready_hold = 0;
  always @(posedge clk) begin : ready_gen
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (r < 55) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(40, 150);
      end else if (r < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", int'(out_status), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_sample !== want.sample)
          report_mismatch("sample", int'(out_sample), int'(want.sample));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_last !== want.last)
          report_mismatch("last", int'(out_last), int'(want.last));
      end
    end
  end

  // Hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wav_pcm16_chunk_decoder_top verification failed");
      $finish;
    end
  end

  initial begin
    cfg_now              = '0;
    cfg_now.sample_limit = SAMPLE_LIMIT_RST;
    restart_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        pause(1);
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        send_byte(DIRECTED[i].start, DIRECTED[i].data, DIRECTED[i].kind, DIRECTED[i].want);
        pause(pick_gap());
      end
    end

    while (random_items < RANDOM_ITEMS) run_random_file();

    pause(1);
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("wav_pcm16_chunk_decoder_top verification clean");
    end else begin
      $display("wav_pcm16_chunk_decoder_top verification failed");
    end
    $finish;
  end

endmodule
